/* rtl/core/drd_pkg.sv */
// Shared types, constants and helper functions of the detection row decoder.
package drd_pkg;

  // Field widths
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ROW_IDX_W  = 16;
  localparam int unsigned CLASS_W    = 7;
  localparam int unsigned NET_W      = 13;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CONF_W     = 17;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 88;

  // Internal datapath widths
  localparam int unsigned DN_W  = 46;  // denormalized coordinate, signed
  localparam int unsigned MAG_W = 46;  // magnitude fed to the scaler
  localparam int unsigned MH_W  = 22;  // high slice of the magnitude
  localparam int unsigned ML_W  = 24;  // low slice of the magnitude
  localparam int unsigned QT_W  = 39;  // scaled result, signed

  // Element positions within a row
  localparam int unsigned ELEM_CX   = 0;
  localparam int unsigned ELEM_CY   = 1;
  localparam int unsigned ELEM_W    = 2;
  localparam int unsigned ELEM_H    = 3;
  localparam int unsigned ELEM_OBJ  = 4;
  localparam int unsigned ELEM_CLS0 = 5;
  localparam int unsigned MIN_ELEMS = 6;

  localparam logic signed [VALUE_W-1:0] TWO_Q16   = 32'sd131072;
  localparam logic [CONF_W-1:0]         CONF_ONE  = 17'd65536;
  localparam logic [NET_W-1:0]          FRAME_MAX = 13'd4096;
  localparam logic signed [QT_W-1:0]    QT_ONE    = 39'sd1;
  localparam logic signed [QT_W-1:0]    QT_FMAX   = 39'sd4096;

  // Row queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NET_SIZE,
    CFG_FRAME_W,
    CFG_FRAME_H,
    CFG_SCALE_X,
    CFG_SCALE_Y,
    CFG_CLASS_ID,
    CFG_CONF_THR
  } cfg_idx_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PROD,
    B_CHECK,
    B_DENORM,
    B_OPND,
    B_MULH,
    B_MULL,
    B_ACC,
    B_CLAMP,
    B_TRIM,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [NET_W-1:0]   net_size;
    logic [NET_W-1:0]   frame_w;
    logic [NET_W-1:0]   frame_h;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [CLASS_W-1:0] class_id;
    logic [CONF_W-1:0]  conf_thr;
  } cfg_t;

  // One finished row as handed from front to back
  typedef struct packed {
    logic                      frame_last;
    logic [ROW_IDX_W-1:0]      row_index;
    logic                      pre_ok;
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic signed [VALUE_W-1:0] obj;
    logic signed [VALUE_W-1:0] best;
  } row_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic                 kept;
    logic [POS_W-1:0]     box_x;
    logic [POS_W-1:0]     box_y;
    logic [LEN_W-1:0]     box_width;
    logic [LEN_W-1:0]     box_height;
    logic [CONF_W-1:0]    confidence;
    logic                 frame_last;
  } res_t;

  // Saturate a frame dimension into [1, 4096]
  function automatic logic [NET_W-1:0] frame_lim(logic [NET_W-1:0] lim);
    if (lim == '0) return NET_W'(1);
    if (lim > FRAME_MAX) return FRAME_MAX;
    return lim;
  endfunction

  // Clamp a left/top edge into [0, f-1]
  function automatic logic [POS_W-1:0] clamp_pos(logic signed [QT_W-1:0] p,
                                                 logic [NET_W-1:0] f);
    logic signed [QT_W-1:0] hi;
    hi = $signed({{(QT_W-NET_W){1'b0}}, f - NET_W'(1)});
    if (p > hi) return hi[POS_W-1:0];
    if (p[QT_W-1]) return '0;
    return p[POS_W-1:0];
  endfunction

  // Raise a size to at least 1; cap at the largest frame, trimmed later
  function automatic logic [LEN_W-1:0] clamp_len(logic signed [QT_W-1:0] l);
    if (l < QT_ONE) return LEN_W'(1);
    if (l > QT_FMAX) return FRAME_MAX;
    return l[LEN_W-1:0];
  endfunction

endpackage

/* rtl/core/drd_front.sv */
// Row front end: captures box fields, runs the class argmax and emits one row record per row.
module drd_front
  import drd_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 128,
  parameter int unsigned MAX_ROWS     = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      row_end_i,
  input  logic                      frame_end_i,
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output row_t                      rec_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMP_W = (CNT_W > CLASS_W) ? CNT_W : CLASS_W;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] E_CX     = CNT_W'(ELEM_CX);
  localparam logic [CNT_W-1:0] E_CY     = CNT_W'(ELEM_CY);
  localparam logic [CNT_W-1:0] E_W      = CNT_W'(ELEM_W);
  localparam logic [CNT_W-1:0] E_H      = CNT_W'(ELEM_H);
  localparam logic [CNT_W-1:0] E_OBJ    = CNT_W'(ELEM_OBJ);
  localparam logic [CNT_W-1:0] E_CLS0   = CNT_W'(ELEM_CLS0);
  localparam logic [CNT_W-1:0] E_MIN    = CNT_W'(MIN_ELEMS);
  localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(MAX_ROWS);

  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          cls_q, cls_d;
  logic signed [VALUE_W-1:0] cx_q, cx_d, cy_q, cy_d, w_q, w_d, h_q, h_d;
  logic signed [VALUE_W-1:0] obj_q, obj_d, best_q, best_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [ROW_W:0]            row_inc;
  logic [ROW_W+ROW_IDX_W-1:0] row_ext;
  logic                      take, last;

  assign in_ready_o = !fifo_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign last       = row_end_i || frame_end_i;
  assign push_o     = take && last;

  // Place the element and advance the argmax
  always_comb begin
    count_d = count_q;
    cls_d   = cls_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    w_d     = w_q;
    h_d     = h_q;
    obj_d   = obj_q;
    best_d  = best_q;
    if (count_q < CNT_MAX) begin
      count_d = count_q + CNT_W'(1);
      if (count_q == E_CX) begin
        cx_d = value_i;
      end else if (count_q == E_CY) begin
        cy_d = value_i;
      end else if (count_q == E_W) begin
        w_d = value_i;
      end else if (count_q == E_H) begin
        h_d = value_i;
      end else if (count_q == E_OBJ) begin
        obj_d = value_i;
      end else if (count_q == E_CLS0) begin
        best_d = value_i;
        cls_d  = '0;
      end else if (value_i > best_q) begin
        best_d = value_i;
        cls_d  = count_q - E_CLS0;
      end
    end
  end

  // Row counter: wrap at the row limit, restart after the frame end
  assign row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
  always_comb begin
    if (frame_end_i || (row_inc >= ROW_LIM)) begin
      row_d = '0;
    end else begin
      row_d = row_inc[ROW_W-1:0];
    end
  end

  assign row_ext = {{ROW_IDX_W{1'b0}}, row_q};

  // Build the row record from the values after this beat
  always_comb begin
    rec_o.frame_last = frame_end_i;
    rec_o.row_index  = row_ext[ROW_IDX_W-1:0];
    rec_o.pre_ok     = (count_d >= E_MIN) && (CMP_W'(cls_d) == CMP_W'(cfg_i.class_id));
    rec_o.cx         = cx_d;
    rec_o.cy         = cy_d;
    rec_o.w          = w_d;
    rec_o.h          = h_d;
    rec_o.obj        = obj_d;
    rec_o.best       = best_d;
  end

  // Hold row state; clear it when the row leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cls_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
      obj_q   <= '0;
      best_q  <= '0;
      row_q   <= '0;
    end else if (take) begin
      if (last) begin
        count_q <= '0;
        cls_q   <= '0;
        cx_q    <= '0;
        cy_q    <= '0;
        w_q     <= '0;
        h_q     <= '0;
        obj_q   <= '0;
        best_q  <= '0;
        row_q   <= row_d;
      end else begin
        count_q <= count_d;
        cls_q   <= cls_d;
        cx_q    <= cx_d;
        cy_q    <= cy_d;
        w_q     <= w_d;
        h_q     <= h_d;
        obj_q   <= obj_d;
        best_q  <= best_d;
      end
    end
  end

endmodule

/* rtl/core/drd_fifo.sv */
// Two-entry row queue between the front end and the box back end.
module drd_fifo
  import drd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  row_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output row_t data_o
);

  row_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

endmodule

/* rtl/core/drd_back.sv */
// Box back end: confidence test, denormalization, scaling, clamping and the result register.
module drd_back
  import drd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic rec_valid_i,
  output logic rec_pop_o,
  input  row_t rec_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  back_state_e state_q, state_d;

  row_t                      rec_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      pre_keep_q, norm_q, keep_q;
  logic [CONF_W-1:0]         conf_q;
  logic [1:0]                step_q;
  logic signed [DN_W-1:0]    dn_q [4];
  logic                      neg_q;
  logic [MAG_W-1:0]          mag_q;
  logic [MH_W+SCALE_W-1:0]   a_q;
  logic [ML_W+SCALE_W-1:0]   b_q;
  logic signed [QT_W-1:0]    qt_q [4];
  logic [POS_W-1:0]          pos_x_q, pos_y_q;
  logic [LEN_W-1:0]          len_x_q, len_y_q;
  logic [NET_W-1:0]          fx_q, fy_q;
  res_t                      res_q;
  logic                      res_valid_q;

  logic                      keep_now, load_res;
  logic signed [PROD_W-1:0]  thr_ext;
  logic signed [VALUE_W-1:0] dn_sel;
  logic signed [DN_W-1:0]    dn_mult, dn_val;
  logic signed [DN_W-1:0]    cen, siz;
  logic signed [DN_W:0]      opnd;
  logic [DN_W:0]             opnd_abs;
  logic [SCALE_W-1:0]        scale;
  logic [MH_W+SCALE_W:0]     acc_sum;
  logic signed [QT_W-1:0]    q_abs, q_sgn;
  logic [NET_W-1:0]          fx, fy;
  logic [LEN_W:0]            end_x, end_y;

  // Confidence test against the threshold
  assign thr_ext  = $signed({31'b0, cfg_i.conf_thr, 16'b0});
  assign keep_now = pre_keep_q && !(prod_q < thr_ext);

  // Denormalize one coordinate per cycle
  always_comb begin
    case (step_q)
      2'd0:    dn_sel = rec_q.cx;
      2'd1:    dn_sel = rec_q.cy;
      2'd2:    dn_sel = rec_q.w;
      default: dn_sel = rec_q.h;
    endcase
  end
  assign dn_mult = dn_sel * $signed({1'b0, cfg_i.net_size});
  assign dn_val  = norm_q ? dn_mult : {{(DN_W-VALUE_W){dn_sel[VALUE_W-1]}}, dn_sel};

  // Scaler operand: 2c - size for the edge, 2 size for the length
  assign cen      = step_q[1] ? dn_q[1] : dn_q[0];
  assign siz      = step_q[1] ? dn_q[3] : dn_q[2];
  assign opnd     = step_q[0] ? {siz, 1'b0} : ({cen, 1'b0} - {siz[DN_W-1], siz});
  assign opnd_abs = opnd[DN_W] ? -opnd : opnd;
  assign scale    = step_q[1] ? cfg_i.scale_y : cfg_i.scale_x;

  // Recombine partial products, drop 33 fraction bits, restore the sign
  assign acc_sum = {1'b0, a_q} + {{(MH_W+1){1'b0}}, b_q[ML_W+SCALE_W-1:ML_W]};
  assign q_abs   = {1'b0, acc_sum[MH_W+SCALE_W:9]};
  assign q_sgn   = neg_q ? -q_abs : q_abs;

  assign fx    = frame_lim(cfg_i.frame_w);
  assign fy    = frame_lim(cfg_i.frame_h);
  assign end_x = {2'b0, pos_x_q} + {1'b0, len_x_q};
  assign end_y = {2'b0, pos_y_q} + {1'b0, len_y_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (rec_valid_i) state_d = B_PROD;
      B_PROD:   state_d = B_CHECK;
      B_CHECK:  state_d = keep_now ? B_DENORM : B_DONE;
      B_DENORM: if (step_q == 2'd3) state_d = B_OPND;
      B_OPND:   state_d = B_MULH;
      B_MULH:   state_d = B_MULL;
      B_MULL:   state_d = B_ACC;
      B_ACC:    state_d = (step_q == 2'd3) ? B_CLAMP : B_OPND;
      B_CLAMP:  state_d = B_TRIM;
      B_TRIM:   state_d = B_DONE;
      B_DONE:   if (!res_valid_q || res_ready_i) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer
  always_comb begin
    rec_pop_o = 1'b0;
    load_res  = 1'b0;
    case (state_q)
      B_IDLE:  rec_pop_o = rec_valid_i;
      B_DONE:  load_res  = !res_valid_q || res_ready_i;
      default: begin
        rec_pop_o = 1'b0;
        load_res  = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CHECK) begin
        step_q <= '0;
      end else if (state_q == B_DENORM || state_q == B_ACC) begin
        step_q <= step_q + 2'd1;
      end
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (rec_valid_i) rec_q <= rec_i;
      end
      B_PROD: begin
        prod_q     <= rec_q.obj * rec_q.best;
        pre_keep_q <= rec_q.pre_ok && !rec_q.obj[VALUE_W-1] && (rec_q.obj != '0);
        norm_q     <= (rec_q.cx <= TWO_Q16) && (rec_q.cy <= TWO_Q16) &&
                      (rec_q.w <= TWO_Q16) && (rec_q.h <= TWO_Q16);
      end
      B_CHECK: begin
        keep_q <= keep_now;
        if (prod_q[PROD_W-1:16] > 48'd65536) begin
          conf_q <= CONF_ONE;
        end else begin
          conf_q <= prod_q[CONF_W+15:16];
        end
      end
      B_DENORM: dn_q[step_q] <= dn_val;
      B_OPND: begin
        neg_q <= opnd[DN_W];
        mag_q <= opnd_abs[MAG_W-1:0];
      end
      B_MULH: a_q <= mag_q[MAG_W-1:ML_W] * scale;
      B_MULL: b_q <= mag_q[ML_W-1:0] * scale;
      B_ACC:  qt_q[step_q] <= q_sgn;
      B_CLAMP: begin
        pos_x_q <= clamp_pos(qt_q[0], fx);
        len_x_q <= clamp_len(qt_q[1]);
        pos_y_q <= clamp_pos(qt_q[2], fy);
        len_y_q <= clamp_len(qt_q[3]);
        fx_q    <= fx;
        fy_q    <= fy;
      end
      B_TRIM: begin
        if (end_x > {1'b0, fx_q}) len_x_q <= fx_q - {1'b0, pos_x_q};
        if (end_y > {1'b0, fy_q}) len_y_q <= fy_q - {1'b0, pos_y_q};
      end
      B_DONE: begin
        if (load_res) begin
          res_q.row_index  <= rec_q.row_index;
          res_q.frame_last <= rec_q.frame_last;
          res_q.kept       <= keep_q;
          res_q.box_x      <= keep_q ? pos_x_q : '0;
          res_q.box_y      <= keep_q ? pos_y_q : '0;
          res_q.box_width  <= keep_q ? len_x_q : '0;
          res_q.box_height <= keep_q ? len_y_q : '0;
          res_q.confidence <= keep_q ? conf_q : '0;
        end
      end
      default: begin
        rec_q <= rec_q;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/detection_row_decoder.sv */
// Top level of the detection row decoder: configuration registers, stream ports and core wiring.
//
// Detector output rows stream in on the slave side as signed Q16.16 elements, one beat
// per element (center x, center y, width, height, objectness, then class scores); tlast
// ends a row and tuser ends the frame. Every row end yields one result beat: kept flag,
// corner box in frame pixels and unsigned Q1.16 confidence, with tlast on the frame's last row.
// The front end takes one element per cycle while the queue is not full and hands finished
// rows to a two-row queue. The back end runs one row at a time through a shared 32x13
// multiplier (denormalize) and a shared 24x24 multiplier (four scaled terms): a kept row
// occupies it longer than a rejected row, which skips both, plus any wait for the result
// beat to be taken. With the result side ready, rows at least as long as their back-end
// time stream at one element per cycle; shorter rows stall the input, on any beat, while
// the queue holds two rows. Configuration writes are taken at any time but belong in
// idle periods.
module detection_row_decoder
  import drd_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 128,
  parameter int unsigned MAX_ROWS     = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // element stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
  input  logic                  s_axis_tlast,   // row_end
  input  logic                  s_axis_tuser,   // frame_end
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] row_index, [16] kept,
                                                // [28:17] box_x, [40:29] box_y,
                                                // [53:41] box_width, [66:54] box_height,
                                                // [83:67] confidence, [87:84] zero
  output logic                  m_axis_tlast    // frame_last
);

  cfg_t cfg_q;
  logic fifo_full, fifo_empty, push, pop;
  row_t rec_in, rec_out;
  res_t res;

  assign cfg_ready_o = 1'b1;

  // Register file writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.net_size <= 13'd320;
      cfg_q.frame_w  <= 13'd320;
      cfg_q.frame_h  <= 13'd240;
      cfg_q.scale_x  <= 24'd65536;
      cfg_q.scale_y  <= 24'd49152;
      cfg_q.class_id <= 7'd0;
      cfg_q.conf_thr <= 17'd22938;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NET_SIZE: cfg_q.net_size <= cfg_data_i[NET_W-1:0];
        CFG_FRAME_W:  cfg_q.frame_w  <= cfg_data_i[NET_W-1:0];
        CFG_FRAME_H:  cfg_q.frame_h  <= cfg_data_i[NET_W-1:0];
        CFG_SCALE_X:  cfg_q.scale_x  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Y:  cfg_q.scale_y  <= cfg_data_i[SCALE_W-1:0];
        CFG_CLASS_ID: cfg_q.class_id <= cfg_data_i[CLASS_W-1:0];
        CFG_CONF_THR: cfg_q.conf_thr <= cfg_data_i[CONF_W-1:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  drd_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .value_i     ($signed(s_axis_tdata)),
    .row_end_i   (s_axis_tlast),
    .frame_end_i (s_axis_tuser),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .rec_o       (rec_in)
  );

  drd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (rec_out)
  );

  drd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (!fifo_empty),
    .rec_pop_o   (pop),
    .rec_i       (rec_out),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0, res.confidence, res.box_height, res.box_width,
                         res.box_y, res.box_x, res.kept, res.row_index};
  assign m_axis_tlast = res.frame_last;

endmodule
